@@ hw/rtl/wrwc_pkg.sv @@
`default_nettype none
package wrwc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Q8    = 1'b1;

  // item operation codes
  localparam logic OP_ACK  = 1'b0;
  localparam logic OP_LOSS = 1'b1;

  localparam logic [31:0] WIN_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] WIN_RESET      = 32'd536;
  localparam logic [15:0] SEG_RESET      = 16'd536;
  localparam logic [15:0] WEIGHT_RESET   = 16'd256;
  localparam logic [15:0] HALF_Q8        = 16'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOW,
    ST_MULT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_APPLY,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic slow;
    logic mult;
    logic div_start;
    logic apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic avoid;
    logic div_busy;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/wrwc_if.sv @@
`default_nettype none
interface wrwc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] segments_acked;
  logic [31:0] bytes_in_flight;

  modport source (output valid, output operation, output segments_acked,
                  output bytes_in_flight, input ready);
  modport sink   (input valid, input operation, input segments_acked,
                  input bytes_in_flight, output ready);
endinterface

interface wrwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window;
  logic [31:0] threshold;
  logic        in_slow_start;

  modport source (output valid, output window, output threshold,
                  output in_slow_start, input ready);
  modport sink   (input valid, input window, input threshold,
                  input in_slow_start, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wrwc_divider.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module wrwc_divider #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               busy
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] count;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem, quotient[DW-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign busy    = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(DW);
    end else if (busy) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], fits};
      rem      <= fits ? VW'(shifted - {1'b0, dvs}) : shifted[VW-1:0];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/wrwc_datapath.sv @@
`default_nettype none
module wrwc_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [wrwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wrwc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_operation,
  input  wire logic [15:0]                        in_segments_acked,
  input  wire logic [31:0]                        in_bytes_in_flight,
  input  wire wrwc_pkg::cmd_t                     cmd,
  output wrwc_pkg::status_t                       status,
  output logic [31:0]                             out_window,
  output logic [31:0]                             out_threshold,
  output logic                                    out_in_slow_start
);
  import wrwc_pkg::*;

  localparam int unsigned PWW = 32 + FRAC_BITS;
  localparam int unsigned DW  = (PWW > 48) ? PWW : 48;

  logic [15:0]     seg_size;
  logic [15:0]     weight;
  logic [31:0]     cw;
  logic [PWW-1:0]  pw;
  logic [31:0]     ssth;
  logic            op_loss;
  logic [15:0]     segs;
  logic [31:0]     bytes;
  logic [47:0]     prod;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size <= SEG_RESET;
      weight   <= WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEGMENT_SIZE: seg_size <= cfg_data;
        REG_WEIGHT_Q8:    weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  // slow start
  logic [32:0] grow;
  logic [31:0] cw_grow;
  logic        slow_take;
  logic [31:0] cw_slow;
  logic [15:0] segs_left;

  assign grow      = {1'b0, cw} + {17'b0, seg_size};
  assign cw_grow   = grow[32] ? WIN_MAX : grow[31:0];
  assign slow_take = (cw < ssth) && (segs != '0);
  assign cw_slow   = slow_take ? cw_grow : cw;
  assign segs_left = slow_take ? segs - 16'd1 : segs;

  assign status.avoid = (cw_slow >= ssth) && (segs_left != '0);

  // shared multiplier operands: seg^2 on acks, bytes*(weight-0.5) on loss
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod_full;
  assign mul_a = op_loss ? bytes : {16'b0, seg_size};
  assign mul_b = op_loss ? weight - HALF_Q8 : seg_size;
  assign prod_full = {16'b0, mul_a} * {32'b0, mul_b};

  // divider
  logic [DW-1:0] div_dividend;
  logic [31:0]   div_divisor;
  logic [DW-1:0] quot;
  logic          div_busy;

  assign div_dividend = op_loss ? DW'(prod) : DW'({prod[31:0], {FRAC_BITS{1'b0}}});
  assign div_divisor  = op_loss ? {16'b0, weight} : ((cw == '0) ? 32'd1 : cw);
  assign status.div_busy = div_busy;

  wrwc_divider #(.DW(DW), .VW(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quot),
    .busy     (div_busy)
  );

  // congestion avoidance update
  logic [PWW-1:0] wf;
  logic [PWW:0]   one;
  logic           resync;
  logic [PWW-1:0] pw_base;
  logic [DW:0]    sum;
  logic           sat;
  logic [PWW-1:0] pw_avoid;

  assign wf      = {cw, {FRAC_BITS{1'b0}}};
  assign one     = (PWW + 1)'(1) << FRAC_BITS;
  assign resync  = ({1'b0, pw} > {1'b0, wf} + one) || ({1'b0, wf} > {1'b0, pw} + one);
  assign pw_base = resync ? wf : pw;
  assign sum     = (DW + 1)'(pw_base) + (DW + 1)'(quot);
  assign sat     = |sum[DW:PWW];
  assign pw_avoid = sat ? {WIN_MAX, {FRAC_BITS{1'b0}}} : sum[PWW-1:0];

  // loss threshold
  logic [31:0] th_w;
  logic [31:0] floor2;
  logic [31:0] th;
  assign th_w   = (weight >= HALF_Q8) ? quot[31:0] : 32'd0;
  assign floor2 = {15'b0, seg_size, 1'b0};
  assign th     = (th_w < floor2) ? floor2 : th_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw   <= WIN_RESET;
      pw   <= {WIN_RESET, {FRAC_BITS{1'b0}}};
      ssth <= WIN_MAX;
    end else if (cmd.slow) begin
      cw <= cw_slow;
      if (slow_take) begin
        pw <= {cw_grow, {FRAC_BITS{1'b0}}};
      end
    end else if (cmd.apply) begin
      if (op_loss) begin
        cw   <= th;
        ssth <= th;
      end else begin
        pw <= pw_avoid;
        cw <= pw_avoid[PWW-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_loss <= in_operation == OP_LOSS;
      segs    <= in_segments_acked;
      bytes   <= in_bytes_in_flight;
    end else if (cmd.slow) begin
      segs <= segs_left;
    end
    if (cmd.mult) begin
      prod <= prod_full;
    end
    if (cmd.load_out) begin
      out_window        <= cw;
      out_threshold     <= ssth;
      out_in_slow_start <= cw < ssth;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/wrwc_ctrl.sv @@
`default_nettype none
module wrwc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_operation,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire wrwc_pkg::status_t   status,
  output wrwc_pkg::cmd_t           cmd
);
  import wrwc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (in_operation == OP_LOSS) ? ST_MULT : ST_SLOW;
        end
      end
      ST_SLOW: begin
        cmd.slow   = 1'b1;
        state_next = status.avoid ? ST_MULT : ST_OUTPUT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!status.div_busy) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/weighted_reno_window_control_top.sv @@
`default_nettype none
// Sequence from the accepting edge: an ack with no avoidance step passes slow start
// and output; a loss passes multiply, divider load and run, apply and output, and an
// ack into congestion avoidance runs slow start first, then the same steps; the
// divider is bit-serial. One item is in work at a time; the next is accepted the
// cycle after the result is loaded, even while that result still waits in the output register.
// Reset (synchronous, rst high): window 536, threshold all ones, default config.
module weighted_reno_window_control_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [wrwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wrwc_pkg::CFG_DATA_W-1:0] cfg_data,
  wrwc_in_if.sink                              req,
  wrwc_out_if.source                           rsp
);
  import wrwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller sequences: slow start, multiply, divide, apply, output
  wrwc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_operation (req.operation),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath holds window state, config, multiplier, divider, result regs
  wrwc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (req.operation),
    .in_segments_acked  (req.segments_acked),
    .in_bytes_in_flight (req.bytes_in_flight),
    .cmd                (cmd),
    .status             (status),
    .out_window         (rsp.window),
    .out_threshold      (rsp.threshold),
    .out_in_slow_start  (rsp.in_slow_start)
  );
endmodule
`default_nettype wire

@@ tb/window_update_check.sv @@
`timescale 1ns / 1ps
// Watches the config port and both channels, tracks the window state per item
// and compares every result item with the oldest prediction.
module window_update_check #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wrwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrwc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  logic                            req_operation,
  input  logic [15:0]                     req_segments,
  input  logic [31:0]                     req_bytes,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  logic [31:0]                     rsp_window,
  input  logic [31:0]                     rsp_threshold,
  input  logic                            rsp_slow_start,
  output int                              fail_count,
  output int                              pending
);
  import wrwc_pkg::*;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] threshold;
    logic        in_slow_start;
  } window_report_t;

  localparam logic [63:0] ONE_FP = 64'd1 << FRAC_BITS;

  window_report_t predicted_reports[$];

  logic [15:0] seg_size;
  logic [15:0] weight_q8;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic [63:0] fine_wnd;

  task automatic grow_on_ack(input logic [15:0] acked);
    logic [31:0] left;
    logic [63:0] grown;
    logic [63:0] wnd_fp;
    logic [63:0] divisor;
    logic [63:0] seg_sq;
    logic [63:0] sum;
    left = 32'(acked);
    if (cwnd < ssthresh) begin
      if (left >= 32'd1) begin
        grown = 64'(cwnd) + 64'(seg_size);
        cwnd = (grown > 64'(WIN_MAX)) ? WIN_MAX : grown[31:0];
        fine_wnd = 64'(cwnd) << FRAC_BITS;
        left = left - 32'd1;
      end else begin
        left = 32'd0;
      end
    end
    if (cwnd >= ssthresh && left > 32'd0) begin
      wnd_fp = 64'(cwnd) << FRAC_BITS;
      divisor = (cwnd != 32'd0) ? 64'(cwnd) : 64'd1;
      seg_sq = 64'(seg_size) * 64'(seg_size);
      // resync when the fine window drifted more than one byte away
      if (fine_wnd > wnd_fp + ONE_FP || wnd_fp > fine_wnd + ONE_FP) fine_wnd = wnd_fp;
      sum = fine_wnd + ((seg_sq << FRAC_BITS) / divisor);
      if ((sum >> FRAC_BITS) > 64'(WIN_MAX)) sum = 64'(WIN_MAX) << FRAC_BITS;
      fine_wnd = sum;
      cwnd = 32'(sum >> FRAC_BITS);
    end
  endtask

  task automatic cut_on_loss(input logic [31:0] bytes);
    logic [63:0] cut;
    logic [63:0] floor2;
    cut = 64'd0;
    floor2 = 64'(seg_size) << 1;
    if (weight_q8 >= HALF_Q8) begin
      cut = (64'(bytes) * 64'(weight_q8 - HALF_Q8)) / 64'(weight_q8);
    end
    if (cut < floor2) cut = floor2;
    ssthresh = cut[31:0];
    cwnd = cut[31:0];
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    window_report_t want;
    if (rst) begin
      seg_size = SEG_RESET;
      weight_q8 = WEIGHT_RESET;
      cwnd = WIN_RESET;
      fine_wnd = 64'(WIN_RESET) << FRAC_BITS;
      ssthresh = WIN_MAX;
      predicted_reports.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SEGMENT_SIZE: seg_size = cfg_data;
          REG_WEIGHT_Q8: weight_q8 = cfg_data;
          default: ;
        endcase
      end
      // compare before pushing: a result never belongs to an item taken this edge
      if (rsp_valid && rsp_ready) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: result with none expected, actual window %0d threshold %0d",
                   $time, rsp_window, rsp_threshold);
          fail_count++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("window", want.window, rsp_window);
          check_field("threshold", want.threshold, rsp_threshold);
          check_field("in_slow_start", 32'(want.in_slow_start), 32'(rsp_slow_start));
        end
      end
      if (req_valid && req_ready) begin
        if (req_operation == OP_LOSS) begin
          cut_on_loss(req_bytes);
        end else begin
          grow_on_ack(req_segments);
        end
        predicted_reports.push_back('{window: cwnd, threshold: ssthresh,
                                      in_slow_start: (cwnd < ssthresh)});
      end
    end
    pending = predicted_reports.size();
  end

endmodule

@@ tb/tb_weighted_reno_window_control_top.sv @@
`timescale 1ns / 1ps
module tb_weighted_reno_window_control_top;
  import wrwc_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  // short slow-start climb from reset at the largest segment
  localparam int RAMP_ITEMS = 24;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SETTINGS_COUNT = 6;
  // drain beyond the longest item
  localparam int DRAIN_CYCLES = 80;
  // upper bound on simulated cycles for the whole run
  localparam longint CYCLE_LIMIT = 4_000_000;

  // config sweep for the random part, extremes included
  localparam logic [15:0] SEG_LIST [SETTINGS_COUNT] =
    '{16'd1460, 16'hFFFF, 16'd1, 16'd9000, 16'hFFFF, 16'd1};
  localparam logic [15:0] WEIGHT_LIST [SETTINGS_COUNT] =
    '{16'd384, 16'hFFFF, 16'd128, 16'd700, 16'd128, 16'hFFFF};

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int     send_idle_pct;
  int     recv_idle_pct;
  int     fail_count;
  int     pending;
  longint cycle_count;

  wrwc_in_if  req ();
  wrwc_out_if rsp ();

  weighted_reno_window_control_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  window_update_check #(
    .FRAC_BITS(FRAC_BITS)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .req_segments  (req.segments_acked),
    .req_bytes     (req.bytes_in_flight),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_window    (rsp.window),
    .rsp_threshold (rsp.threshold),
    .rsp_slow_start(rsp.in_slow_start),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: back-pressure drawn fresh every falling edge
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One item on the request channel. Gaps go low at falling edges; once
  // valid is up it holds until a rising edge sees ready.
  task automatic send_item(input logic op, input logic [15:0] segs,
                           input logic [31:0] bytes);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.segments_acked <= segs;
    req.bytes_in_flight <= bytes;
    do @(posedge clk); while (!req.ready);
  endtask

  // drop valid and hold off until every predicted result is in
  task automatic drain_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_config(input logic [15:0] seg, input logic [15:0] weight);
    drain_results();
    write_reg(REG_SEGMENT_SIZE, seg);
    write_reg(REG_WEIGHT_Q8, weight);
  endtask

  // Mostly acks with few segments so the window walks through avoidance;
  // losses pull it back down. Unused fields carry random noise.
  task automatic random_item();
    int          pick;
    logic        op;
    logic [15:0] segs;
    logic [31:0] bytes;
    pick = $urandom_range(99);
    op = (pick < 15) ? OP_LOSS : OP_ACK;
    segs = 16'($urandom);
    bytes = $urandom;
    pick = $urandom_range(99);
    if (op == OP_LOSS) begin
      if (pick < 10) bytes = '0;
      else if (pick < 20) bytes = '1;
      else if (pick < 50) bytes = $urandom_range(0, 400000);
    end else begin
      if (pick < 10) segs = '0;
      else if (pick < 20) segs = 16'd1;
      else if (pick < 25) segs = '1;
      else if (pick < 75) segs = 16'($urandom_range(1, 8));
    end
    send_item(op, segs, bytes);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SEGMENT_SIZE;
    cfg_data = '0;
    req.valid = 1'b0;
    req.operation = OP_ACK;
    req.segments_acked = '0;
    req.bytes_in_flight = '0;
    send_idle_pct = 17;
    recv_idle_pct = 47;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // slow start at reset config: nothing acked, one segment, a huge ack
    send_item(OP_ACK, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_ACK, 16'd1, 32'd0);
    send_item(OP_ACK, 16'hFFFF, 32'd0);

    // slow start at the largest segment, extra acked segments are dropped
    set_config(16'hFFFF, WEIGHT_RESET);
    for (int i = 0; i < RAMP_ITEMS; i++) begin
      send_item(OP_ACK, 16'($urandom_range(1, 3)), $urandom);
    end
    send_item(OP_ACK, 16'hFFFF, 32'd0);
    send_item(OP_ACK, 16'hFFFF, 32'd0);
    send_item(OP_ACK, 16'd1, 32'd0);

    // ack with nothing acked, then loss at the widest flight size;
    // the next ack has to resync the stale fine window
    send_item(OP_ACK, 16'd0, 32'd0);
    send_item(OP_LOSS, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_ACK, 16'd1, 32'd0);
    send_item(OP_ACK, 16'hFFFF, 32'd0);
    // empty flight: threshold falls back to two segments
    send_item(OP_LOSS, 16'd0, 32'd0);
    send_item(OP_ACK, 16'd1, 32'd0);
    send_item(OP_ACK, 16'd2, 32'd0);

    // smallest segment, heaviest weight
    set_config(16'd1, 16'hFFFF);
    send_item(OP_LOSS, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_ACK, 16'hFFFF, 32'd0);
    send_item(OP_ACK, 16'd1, 32'd0);

    // weight of exactly one half: weighted term is zero
    set_config(16'hFFFF, HALF_Q8);
    send_item(OP_LOSS, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_ACK, 16'd1, 32'd0);

    // random part: two config settings per idling profile
    for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_config(SEG_LIST[ph], WEIGHT_LIST[ph]);
      for (int n = 0; n < RANDOM_ITEMS / SETTINGS_COUNT; n++) begin
        // now and then let the pipe run completely dry
        if ($urandom_range(99) == 0) drain_results();
        random_item();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ weighted_reno_window_control_top.f @@
hw/rtl/wrwc_pkg.sv
hw/rtl/wrwc_if.sv
hw/rtl/wrwc_divider.sv
hw/rtl/wrwc_datapath.sv
hw/rtl/wrwc_ctrl.sv
hw/rtl/weighted_reno_window_control_top.sv
tb/window_update_check.sv
tb/tb_weighted_reno_window_control_top.sv
